/* design/world_point_to_grid_tile_macros.svh */
// Assertion helpers shared by the grid tile design
`ifndef WORLD_POINT_TO_GRID_TILE_MACROS_SVH
`define WORLD_POINT_TO_GRID_TILE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WPGT_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define WPGT_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

/* design/wpgt_pkg.sv */
`timescale 1ns / 1ps
package wpgt_pkg;

  localparam int COORD_W = 32;
  localparam int CFG_W   = 24;
  localparam int DVD_W   = 33;  // dividend and quotient width
  localparam int REM_W   = 25;  // divisor and remainder width
  localparam int LANES   = 3;
  localparam int LANE_A  = 0;   // column (square: x)
  localparam int LANE_B  = 1;   // even row (square: y)
  localparam int LANE_C  = 2;   // odd row
  localparam int WIDE_W  = 35;
  localparam int IDX_W   = 36;
  localparam int ERR_W   = 26;
  localparam int DX_W    = 28;
  localparam int DM_W    = 27;
  localparam int SQ_W    = 54;
  localparam int DIST_W  = 55;
  localparam int OFS_W   = 3;

  typedef enum logic [1:0] {
    REG_GRID_IS_HEX        = 2'd0,
    REG_TILE_SIZE          = 2'd1,
    REG_HEX_COLUMN_SPACING = 2'd2,
    REG_HEX_ROW_HEIGHT     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] work;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic                   hex;
    lane_t [LANES-1:0]      lane;
  } dv_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic                      clamped;
  } tile_t;

endpackage

/* design/world_point_to_grid_tile.sv */
`timescale 1ns / 1ps
`include "world_point_to_grid_tile_macros.svh"
// Channel  Handshake            Word
// in       in_valid/in_ready    world_x, world_y
// out      out_valid/out_ready  tile_column, tile_row, clamped
// cfg      cfg_write            cfg_index, cfg_data
//
// One word per cycle in and out, stalled while the skid register is full; fully pipelined:
// prep, 33 divider cells, 4 search stages, clog2((2R+1)^2) minimum tree levels, output register.
// Reset clears valid flags and loads register defaults; payload registers are not reset.
// out_ready low parks one word in the output register and one in a skid register;
// in_ready drops only while the skid register is full, which stalls the whole pipeline.
module world_point_to_grid_tile
  import wpgt_pkg::*;
#(
  parameter int SEARCH_RADIUS = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] world_x,
  input  logic signed [COORD_W-1:0] world_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] tile_column,
  output logic signed [COORD_W-1:0] tile_row,
  output logic                      clamped
);

  function automatic logic [DVD_W-1:0] mag_add(input logic signed [WIDE_W-1:0] v,
                                               input logic signed [WIDE_W-1:0] add);
    logic signed [WIDE_W-1:0] a;
    a = (v < 0) ? -v : v;
    return DVD_W'(a + add);
  endfunction

  // Configuration registers
  logic             grid_is_hex;
  logic [CFG_W-1:0] tile_size, hex_column_spacing, hex_row_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_is_hex        <= 1'b0;
      tile_size          <= CFG_W'(8192);
      hex_column_spacing <= CFG_W'(6144);
      hex_row_height     <= CFG_W'(7094);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_IS_HEX:        grid_is_hex        <= cfg_data[0];
        REG_TILE_SIZE:          tile_size          <= cfg_data;
        REG_HEX_COLUMN_SPACING: hex_column_spacing <= cfg_data;
        REG_HEX_ROW_HEIGHT:     hex_row_height     <= cfg_data;
      endcase
    end
  end

  // Zero registers act as one
  logic [CFG_W-1:0] t_eff, s_eff, h_eff;
  assign t_eff = (tile_size == '0) ? CFG_W'(1) : tile_size;
  assign s_eff = (hex_column_spacing == '0) ? CFG_W'(1) : hex_column_spacing;
  assign h_eff = (hex_row_height == '0) ? CFG_W'(1) : hex_row_height;

  // Divisors per lane
  logic [LANES-1:0][REM_W-1:0] dvs;
  always_comb begin
    if (grid_is_hex) begin
      dvs[LANE_A] = {s_eff, 1'b0};
      dvs[LANE_B] = {h_eff, 1'b0};
      dvs[LANE_C] = {h_eff, 1'b0};
    end else begin
      dvs[LANE_A] = REM_W'(t_eff);
      dvs[LANE_B] = REM_W'(t_eff);
      dvs[LANE_C] = REM_W'(t_eff);
    end
  end

  // Build dividends from the incoming point
  logic signed [WIDE_W-1:0] x_w, y_w, t_w, s_w, h_w, n_col, m_even, m_odd;
  dv_word_t                 prep_next;

  assign x_w    = WIDE_W'(world_x);
  assign y_w    = WIDE_W'(world_y);
  assign t_w    = WIDE_W'(t_eff);
  assign s_w    = WIDE_W'(s_eff);
  assign h_w    = WIDE_W'(h_eff);
  assign n_col  = (x_w <<< 1) - t_w;
  assign m_even = (y_w <<< 1) - h_w;
  assign m_odd  = (y_w <<< 1) - (h_w <<< 1);

  always_comb begin
    prep_next     = '0;
    prep_next.hex = grid_is_hex;
    if (grid_is_hex) begin
      prep_next.lane[LANE_A].work = mag_add(n_col, s_w);
      prep_next.lane[LANE_A].neg  = n_col < 0;
      prep_next.lane[LANE_B].work = mag_add(m_even, h_w);
      prep_next.lane[LANE_B].neg  = m_even < 0;
      prep_next.lane[LANE_C].work = mag_add(m_odd, h_w);
      prep_next.lane[LANE_C].neg  = m_odd < 0;
    end else begin
      // floor of a negative quotient is minus the ceiling of the magnitudes
      prep_next.lane[LANE_A].work = mag_add(x_w, world_x[COORD_W-1] ? t_w - 1 : '0);
      prep_next.lane[LANE_A].neg  = world_x[COORD_W-1];
      prep_next.lane[LANE_B].work = mag_add(y_w, world_y[COORD_W-1] ? t_w - 1 : '0);
      prep_next.lane[LANE_B].neg  = world_y[COORD_W-1];
    end
  end

  // Pipeline moves whenever the skid register is free
  logic     adv, skid_full;
  logic     prep_valid;
  dv_word_t prep_word;

  assign adv      = !skid_full;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (adv) begin
      prep_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_word <= prep_next;
    end
  end

  logic     div_valid;
  dv_word_t div_word;

  wpgt_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .dvs       (dvs),
    .in_valid  (prep_valid),
    .in_word   (prep_word),
    .out_valid (div_valid),
    .out_word  (div_word)
  );

  logic  search_valid;
  tile_t search_res;

  wpgt_search #(
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s_eff     (s_eff),
    .h_eff     (h_eff),
    .in_valid  (div_valid),
    .in_word   (div_word),
    .out_valid (search_valid),
    .res       (search_res)
  );

  // Output register with one skid entry
  tile_t skid;
  logic  push;
  assign push = search_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_ready) begin
        tile_column <= skid.col;
        tile_row    <= skid.row;
        clamped     <= skid.clamped;
      end
    end else if (push) begin
      if (!out_valid || out_ready) begin
        tile_column <= search_res.col;
        tile_row    <= search_res.row;
        clamped     <= search_res.clamped;
      end else begin
        skid <= search_res;
      end
    end
  end

  `WPGT_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_full, out_valid)
  `WPGT_ASSERT_NEXT(a_skid_fill, clk, rst, !skid_full && search_valid && out_valid && !out_ready, skid_full)

endmodule

/* design/wpgt_div_cell.sv */
`timescale 1ns / 1ps
module wpgt_div_cell
  import wpgt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [LANES-1:0][REM_W-1:0] dvs,
  input  logic                        in_valid,
  input  dv_word_t                    in_word,
  output logic                        out_valid,
  output dv_word_t                    out_word
);

  dv_word_t word_next;

  // One restoring step per lane: bring down the top dividend bit, try subtract
  always_comb begin
    logic [REM_W:0] part;
    logic [REM_W:0] diff;
    logic           qbit;
    word_next = in_word;
    for (int l = 0; l < LANES; l++) begin
      part = {in_word.lane[l].rem, in_word.lane[l].work[DVD_W-1]};
      diff = part - {1'b0, dvs[l]};
      qbit = (part >= {1'b0, dvs[l]});
      word_next.lane[l].rem  = qbit ? diff[REM_W-1:0] : part[REM_W-1:0];
      word_next.lane[l].work = {in_word.lane[l].work[DVD_W-2:0], qbit};
    end
  end

  // Advance the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word_next;
    end
  end

endmodule

/* design/wpgt_divider.sv */
`timescale 1ns / 1ps
`include "world_point_to_grid_tile_macros.svh"
module wpgt_divider
  import wpgt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [LANES-1:0][REM_W-1:0] dvs,
  input  logic                        in_valid,
  input  dv_word_t                    in_word,
  output logic                        out_valid,
  output dv_word_t                    out_word
);

  logic     valid [0:DVD_W];
  dv_word_t word  [0:DVD_W];

  assign valid[0] = in_valid;
  assign word[0]  = in_word;

  // One cell per quotient bit, most significant first
  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    wpgt_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .dvs       (dvs),
      .in_valid  (valid[i]),
      .in_word   (word[i]),
      .out_valid (valid[i+1]),
      .out_word  (word[i+1])
    );
  end

  assign out_valid = valid[DVD_W];
  assign out_word  = word[DVD_W];

  for (genvar gl = 0; gl < LANES; gl++) begin : g_chk
    `WPGT_ASSERT_IMPLY(a_rem_below_divisor, clk, rst, valid[DVD_W], word[DVD_W].lane[gl].rem < dvs[gl])
  end

endmodule

/* design/wpgt_search.sv */
`timescale 1ns / 1ps
`include "world_point_to_grid_tile_macros.svh"
module wpgt_search
  import wpgt_pkg::*;
#(
  parameter int SEARCH_RADIUS = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [CFG_W-1:0] s_eff,
  input  logic [CFG_W-1:0] h_eff,
  input  logic             in_valid,
  input  dv_word_t         in_word,
  output logic             out_valid,
  output tile_t            res
);

  localparam int SPAN  = 2 * SEARCH_RADIUS + 1;
  localparam int NCAND = SPAN * SPAN;
  localparam int LV    = $clog2(NCAND);
  localparam int PAD   = 1 << LV;

  typedef struct packed {
    logic                      hex;
    logic signed [IDX_W-1:0]   est_col;
    logic signed [IDX_W-1:0]   est_row_even;
    logic signed [IDX_W-1:0]   est_row_odd;
  } est_t;

  typedef struct packed {
    logic              real_cand;
    logic [DIST_W-1:0] dist_sq;
    logic [OFS_W-1:0]  k;
    logic [OFS_W-1:0]  j;
  } cand_t;

  function automatic cand_t pick(input cand_t a, input cand_t b);
    // earlier candidate wins a tie
    if (b.real_cand && (!a.real_cand || b.dist_sq < a.dist_sq)) begin
      return b;
    end
    return a;
  endfunction

  function automatic logic [COORD_W:0] sat(input logic signed [IDX_W-1:0] v);
    logic signed [IDX_W-1:0] hi;
    logic signed [IDX_W-1:0] lo;
    hi = IDX_W'($signed(32'h7FFF_FFFF));
    lo = IDX_W'($signed(32'h8000_0000));
    if (v > hi) begin
      return {1'b1, hi[COORD_W-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[COORD_W-1:0]};
    end
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  function automatic logic signed [IDX_W-1:0] est_of(input lane_t ln);
    logic signed [IDX_W-1:0] q;
    q = IDX_W'(ln.work);
    return ln.neg ? -q : q;
  endfunction

  function automatic logic signed [ERR_W-1:0] err_of(input lane_t ln,
                                                     input logic [CFG_W-1:0] half);
    logic signed [ERR_W-1:0] r;
    logic signed [ERR_W-1:0] p;
    r = ERR_W'(ln.rem);
    p = ERR_W'(half);
    return ln.neg ? p - r : r - p;
  endfunction

  // ---- estimate stage: signed estimates and rounding errors
  logic                    ev;
  est_t                    e_est;
  logic signed [ERR_W-1:0] e_ex, e_ey [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else if (adv) begin
      ev <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_est.hex          <= in_word.hex;
      e_est.est_col      <= est_of(in_word.lane[LANE_A]);
      e_est.est_row_even <= est_of(in_word.lane[LANE_B]);
      e_est.est_row_odd  <= est_of(in_word.lane[LANE_C]);
      e_ex               <= err_of(in_word.lane[LANE_A], s_eff);
      e_ey[0]            <= err_of(in_word.lane[LANE_B], h_eff);
      e_ey[1]            <= err_of(in_word.lane[LANE_C], h_eff);
    end
  end

  // ---- offset stage: distance components to each candidate center
  logic               dv;
  est_t               d_est;
  logic [DM_W-1:0]    dmx [0:SPAN-1];
  logic [DM_W-1:0]    dmy [0:1][0:SPAN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else if (adv) begin
      dv <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_est <= e_est;
    end
  end

  for (genvar k = 0; k < SPAN; k++) begin : g_dx
    localparam logic signed [DX_W-1:0] TWO_K = DX_W'(2 * (k - SEARCH_RADIUS));
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy [0:1];
    assign dx    = TWO_K * $signed(DX_W'(s_eff)) - DX_W'(e_ex);
    assign dy[0] = TWO_K * $signed(DX_W'(h_eff)) - DX_W'(e_ey[0]);
    assign dy[1] = TWO_K * $signed(DX_W'(h_eff)) - DX_W'(e_ey[1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        dmx[k]    <= dx < 0 ? DM_W'(-dx) : DM_W'(dx);
        dmy[0][k] <= dy[0] < 0 ? DM_W'(-dy[0]) : DM_W'(dy[0]);
        dmy[1][k] <= dy[1] < 0 ? DM_W'(-dy[1]) : DM_W'(dy[1]);
      end
    end
  end

  // ---- square stage
  logic            qv;
  est_t            q_est;
  logic [SQ_W-1:0] sqx [0:SPAN-1];
  logic [SQ_W-1:0] sqy [0:1][0:SPAN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (adv) begin
      qv <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_est <= d_est;
      for (int k = 0; k < SPAN; k++) begin
        sqx[k]    <= dmx[k] * dmx[k];
        sqy[0][k] <= dmy[0][k] * dmy[0][k];
        sqy[1][k] <= dmy[1][k] * dmy[1][k];
      end
    end
  end

  // ---- leaf stage and registered minimum tree
  logic  sv   [0:LV];
  est_t  sd   [0:LV];
  cand_t node [0:LV][0:PAD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= q_est;
    end
  end

  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < NCAND) begin : g_real
      localparam int  KI   = i / SPAN;
      localparam int  JI   = i % SPAN;
      localparam logic KODD = ((KI - SEARCH_RADIUS) % 2) != 0;
      logic par;
      assign par = q_est.est_col[0] ^ KODD;
      always_ff @(posedge clk) begin
        if (adv) begin
          node[0][i].real_cand <= 1'b1;
          node[0][i].dist_sq   <= DIST_W'(sqx[KI]) + DIST_W'(sqy[par][JI]);
          node[0][i].k         <= OFS_W'(KI);
          node[0][i].j         <= OFS_W'(JI);
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (adv) begin
          node[0][i] <= '0;
        end
      end
    end
  end

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[l] <= 1'b0;
      end else if (adv) begin
        sv[l] <= sv[l-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sd[l] <= sd[l-1];
      end
    end
    for (genvar i = 0; i < PAD; i++) begin : g_node
      if (i < (PAD >> l)) begin : g_pick
        always_ff @(posedge clk) begin
          if (adv) begin
            node[l][i] <= pick(node[l-1][2*i], node[l-1][2*i+1]);
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          if (adv) begin
            node[l][i] <= '0;
          end
        end
      end
    end
  end

  // ---- final index and saturation
  always_comb begin
    logic signed [IDX_W-1:0] ko;
    logic signed [IDX_W-1:0] jo;
    logic signed [IDX_W-1:0] col_w;
    logic signed [IDX_W-1:0] row_w;
    logic [COORD_W:0]        cs;
    logic [COORD_W:0]        rs;
    ko = IDX_W'(node[LV][0].k) - IDX_W'(SEARCH_RADIUS);
    jo = IDX_W'(node[LV][0].j) - IDX_W'(SEARCH_RADIUS);
    if (sd[LV].hex) begin
      col_w = sd[LV].est_col + ko;
      row_w = ((sd[LV].est_col[0] ^ ko[0]) ? sd[LV].est_row_odd : sd[LV].est_row_even) + jo;
    end else begin
      col_w = sd[LV].est_col;
      row_w = sd[LV].est_row_even;
    end
    cs = sat(col_w);
    rs = sat(row_w);
    res.col     = cs[COORD_W-1:0];
    res.row     = rs[COORD_W-1:0];
    res.clamped = cs[COORD_W] | rs[COORD_W];
  end

  assign out_valid = sv[LV];

  `WPGT_ASSERT_IMPLY(a_winner_real, clk, rst, sv[LV] && sd[LV].hex, node[LV][0].real_cand)
  `WPGT_ASSERT_IMPLY(a_square_no_clamp, clk, rst, sv[LV] && !sd[LV].hex, !res.clamped)

endmodule
